>>> hdl/ars_pkg.sv
// Shared types, constants and the arctangent table for the arc reachability block.
// Used by the CORDIC cell, the divider and the top level.
`timescale 1ns / 1ps
package ars_pkg;

  localparam int CW = 38;   // CORDIC x/y width
  localparam int ZW = 24;   // CORDIC angle width, Q16 radians

  localparam logic signed [ZW-1:0] PI16      = 24'sd205887;
  localparam logic signed [ZW-1:0] HALF_PI16 = 24'sd102944;
  localparam logic signed [ZW-1:0] TWO_PI16  = 24'sd411775;
  localparam logic [29:0]          INV_GAIN  = 30'd652032874;
  localparam logic [30:0]          SAT31     = 31'h7FFF_FFFF;
  localparam logic [31:0]          NEG_ONE   = 32'hFFFF_0000;

  localparam logic [2:0] REG_WHEELBASE = 3'd0;
  localparam logic [2:0] REG_MAX_STEER = 3'd1;
  localparam logic [2:0] REG_RATIO     = 3'd2;
  localparam logic [2:0] REG_INV_SPEED = 3'd3;
  localparam logic [2:0] REG_FLAG      = 3'd4;

  localparam logic [15:0] WHEELBASE_RST = 16'd678;
  localparam logic [14:0] MAX_STEER_RST = 15'd4096;
  localparam logic [15:0] RATIO_RST     = 16'd4429;
  localparam logic [31:0] INV_SPEED_RST = 32'd65536;

  typedef struct packed {
    logic          valid;
    logic          vec;     // 1: vectoring, 0: rotation
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [ZW-1:0] z;
  } cdc_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  function automatic logic [16:0] atan_q16(input int unsigned i);
    logic [16:0] r;
    case (i)
      0: r = 17'd51472;  1: r = 17'd30386;  2: r = 17'd16055;  3: r = 17'd8150;
      4: r = 17'd4091;   5: r = 17'd2047;   6: r = 17'd1024;   7: r = 17'd512;
      8: r = 17'd256;    9: r = 17'd128;    10: r = 17'd64;    11: r = 17'd32;
      12: r = 17'd16;    13: r = 17'd8;     14: r = 17'd4;     15: r = 17'd2;
      16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // wrap to (-pi, pi], four correction passes
  function automatic logic signed [ZW-1:0] wrap16(input logic signed [ZW-1:0] a_in);
    logic signed [ZW-1:0] a;
    a = a_in;
    for (int k = 0; k < 4; k++) begin
      if (a > PI16) a = a - TWO_PI16;
      else if (a <= -PI16) a = a + TWO_PI16;
    end
    return a;
  endfunction

endpackage

>>> hdl/arc_reachability_and_steering.sv
// Arc reachability and steering check, top level.
// Depends on ars_pkg, ars_cordic_cell and ars_divider.
`timescale 1ns / 1ps
// One transaction carries an origin pose and a goal point; one result transaction
// follows with the arc length, travel time, end heading, held steering command
// and reachable flag. Items are processed one at a time; the block turns ready
// for the next input as the result is presented. The row of CORDIC_STEPS cells
// is passed three times (bearing/distance, sine, steering angle). The 31 step
// divider for the arc length overlaps the last pass and sets the pace while
// CORDIC_STEPS is 30 or less; above that the last pass does. A stall on the
// output holds the next result back. A finished result waits in the output
// register while the next item is taken.
// Registers sit on an APB port at byte addresses 4*i; writes only while idle.
module arc_reachability_and_steering #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [15:0] origin_heading,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic               update_steering,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] path_length,
  output logic signed [31:0] travel_time,
  output logic signed [15:0] end_heading,
  output logic signed [31:0] steering_command,
  output logic               reachable
);

  localparam int CW = ars_pkg::CW;
  localparam int ZW = ars_pkg::ZW;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_VEC1  = 10'b0000000010,
    S_MAG1  = 10'b0000000100,
    S_MAG2  = 10'b0000001000,
    S_ANG   = 10'b0000010000,
    S_SIN   = 10'b0000100000,
    S_PREP  = 10'b0001000000,
    S_START = 10'b0010000000,
    S_WAIT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t st;

  // ---------------- configuration ----------------
  logic [15:0] wheelbase;
  logic [14:0] max_steer_limit;
  logic [15:0] steer_ratio;
  logic [31:0] inverse_speed;
  logic        flag_unreachable;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase        <= ars_pkg::WHEELBASE_RST;
      max_steer_limit  <= ars_pkg::MAX_STEER_RST;
      steer_ratio      <= ars_pkg::RATIO_RST;
      inverse_speed    <= ars_pkg::INV_SPEED_RST;
      flag_unreachable <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        ars_pkg::REG_WHEELBASE: wheelbase        <= pwdata[15:0];
        ars_pkg::REG_MAX_STEER: max_steer_limit  <= pwdata[14:0];
        ars_pkg::REG_RATIO:     steer_ratio      <= pwdata[15:0];
        ars_pkg::REG_INV_SPEED: inverse_speed    <= pwdata;
        ars_pkg::REG_FLAG:      flag_unreachable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ars_pkg::REG_WHEELBASE: prdata = {16'd0, wheelbase};
      ars_pkg::REG_MAX_STEER: prdata = {17'd0, max_steer_limit};
      ars_pkg::REG_RATIO:     prdata = {16'd0, steer_ratio};
      ars_pkg::REG_INV_SPEED: prdata = inverse_speed;
      ars_pkg::REG_FLAG:      prdata = {31'd0, flag_unreachable};
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------- CORDIC cell row ----------------
  ars_pkg::cdc_t chain_in;
  ars_pkg::cdc_t stage [0:CORDIC_STEPS];

  assign stage[0] = chain_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    ars_cordic_cell #(.IDX(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .din (stage[i]),
      .dout(stage[i+1])
    );
  end

  ars_pkg::cdc_t row_out;
  assign row_out = stage[CORDIC_STEPS];

  // ---------------- divider ----------------
  logic               div_start;
  ars_pkg::div_stat_t div_stat;
  logic [30:0]        div_quot;
  logic [53:0]        num;
  logic [30:0]        s_q30;

  ars_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (s_q30),
    .stat (div_stat),
    .quot (div_quot)
  );

  // ---------------- datapath registers ----------------
  logic signed [15:0]   heading;
  logic                 upd;
  logic                 goal_zero;
  logic signed [ZW-1:0] theta;
  logic [36:0]          xmag;
  logic [46:0]          plo;
  logic [35:0]          d;
  logic signed [ZW-1:0] alpha;
  logic [17:0]          a_abs;
  logic signed [15:0]   end13;
  logic signed [26:0]   n_steer;
  logic signed [ZW-1:0] steer16;
  logic                 vec_done;
  logic                 need_div;
  logic [30:0]          len;
  logic [62:0]          tprod;
  logic [31:0]          steering_hold;

  // input pre-rotation for the left half plane
  logic signed [32:0]   dx, dy;
  logic signed [CW-1:0] dxe, dye, px, py;
  logic signed [ZW-1:0] pz;

  assign dx  = $signed({goal_x[31], goal_x}) - $signed({origin_x[31], origin_x});
  assign dy  = $signed({goal_y[31], goal_y}) - $signed({origin_y[31], origin_y});
  assign dxe = CW'(dx);
  assign dye = CW'(dy);

  always_comb begin
    px = dxe;
    py = dye;
    pz = '0;
    if (dx < 0) begin
      if (dy >= 0) begin
        px = dye;
        py = -dxe;
        pz = ars_pkg::HALF_PI16;
      end else begin
        px = -dye;
        py = dxe;
        pz = -ars_pkg::HALF_PI16;
      end
    end
  end

  // bearing, its magnitude folded into the first quadrant, end heading
  logic signed [ZW-1:0] h8;
  logic signed [ZW-1:0] alpha_c, a_c, b_c, end16_c, end_rnd;

  assign h8      = {{(ZW-19){heading[15]}}, heading, 3'b000};
  assign alpha_c = goal_zero ? '0 : ars_pkg::wrap16(theta - h8);
  assign a_c     = alpha_c[ZW-1] ? -alpha_c : alpha_c;
  assign b_c     = (a_c > ars_pkg::HALF_PI16) ? ars_pkg::PI16 - a_c : a_c;
  assign end16_c = ars_pkg::wrap16(h8 + (alpha <<< 1));
  assign end_rnd = end16_c + ZW'(4);

  // steering numerator 2*L*sin(alpha), Q16
  logic [47:0] nprod;
  assign nprod = {wheelbase, 1'b0} * s_q30;

  // arc length selection
  logic [30:0] len_c;
  always_comb begin
    if (d == '0) len_c = '0;
    else if (a_abs == '0) len_c = (d > {5'd0, ars_pkg::SAT31}) ? ars_pkg::SAT31 : d[30:0];
    else if (s_q30 == '0 || div_stat.ovf) len_c = ars_pkg::SAT31;
    else len_c = div_quot;
  end

  assign div_start = (st == S_START) && (d != '0) && (a_abs != '0) && (s_q30 != '0);

  // result assembly
  logic signed [ZW-1:0] steer_rnd;
  logic signed [20:0]   steer13;
  logic [20:0]          mag13;
  logic [36:0]          mprod;
  logic [28:0]          m_cmd;
  logic                 reach_c;
  logic [30:0]          tim_c;
  logic                 out_free;

  assign steer_rnd = steer16 + ZW'(4);
  assign steer13   = steer_rnd[ZW-1:3];
  assign mag13     = steer13[20] ? 21'(-steer13) : steer13;
  assign reach_c   = mag13 < {6'd0, max_steer_limit};
  assign mprod     = mag13 * steer_ratio;
  assign m_cmd     = mprod[36:8];
  assign tim_c     = (tprod[62:16] > {16'd0, ars_pkg::SAT31}) ? ars_pkg::SAT31
                                                              : tprod[46:16];
  assign out_free  = ~out_valid | out_ready;
  assign in_ready  = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_IDLE;
      chain_in.valid <= 1'b0;
      out_valid      <= 1'b0;
      steering_hold  <= '0;
      vec_done       <= 1'b0;
    end else begin
      chain_in.valid <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            chain_in.valid <= 1'b1;
            st             <= S_VEC1;
          end
        end
        S_VEC1:  if (row_out.valid) st <= S_MAG1;
        S_MAG1:  st <= S_MAG2;
        S_MAG2:  st <= S_ANG;
        S_ANG: begin
          chain_in.valid <= 1'b1;
          st             <= S_SIN;
        end
        S_SIN:   if (row_out.valid) st <= S_PREP;
        S_PREP:  st <= S_START;
        S_START: begin
          chain_in.valid <= 1'b1;
          vec_done       <= 1'b0;
          st             <= S_WAIT;
        end
        S_WAIT: begin
          if (row_out.valid) vec_done <= 1'b1;
          if (vec_done && (!need_div || div_stat.done)) st <= S_DONE;
        end
        S_DONE: begin
          // tprod was loaded on the way in; wait for the output register
          if (out_free && vec_done == 1'b0) begin
            out_valid <= 1'b1;
            if (upd) steering_hold <= steer13[20] ? 32'(0 - {3'd0, m_cmd})
                                                  : {3'd0, m_cmd};
            st <= S_IDLE;
          end
          vec_done <= 1'b0;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        heading     <= origin_heading;
        upd         <= update_steering;
        goal_zero   <= (dx == '0) && (dy == '0);
        chain_in.vec <= 1'b1;
        chain_in.x  <= px;
        chain_in.y  <= py;
        chain_in.z  <= pz;
      end
      S_VEC1: begin
        theta <= goal_zero ? '0 : $signed(row_out.z);
        xmag  <= row_out.x[CW-1] ? '0 : row_out.x[36:0];
      end
      S_MAG1: plo <= xmag[16:0] * ars_pkg::INV_GAIN;
      S_MAG2: begin
        d <= goal_zero ? '0
           : 36'(({50'(xmag[36:17]) * 50'(ars_pkg::INV_GAIN), 17'd0} + {20'd0, plo}
                  + 67'd536870912) >> 30);
      end
      S_ANG: begin
        alpha        <= alpha_c;
        a_abs        <= a_c[17:0];
        chain_in.vec <= 1'b0;
        chain_in.x   <= CW'(ars_pkg::INV_GAIN);
        chain_in.y   <= '0;
        chain_in.z   <= b_c;
      end
      S_SIN: begin
        if (row_out.y[CW-1]) s_q30 <= '0;
        else if ($signed(row_out.y) > $signed(CW'(1) <<< 30)) s_q30 <= 31'h4000_0000;
        else s_q30 <= row_out.y[30:0];
      end
      S_PREP: begin
        num     <= d * a_abs;
        n_steer <= alpha[ZW-1] ? -$signed({1'b0, nprod[47:22]})
                               : $signed({1'b0, nprod[47:22]});
        end13   <= end_rnd[18:3];
      end
      S_START: begin
        need_div     <= div_start;
        chain_in.vec <= 1'b1;
        chain_in.x   <= {2'b00, d};
        chain_in.y   <= CW'(n_steer);
        chain_in.z   <= '0;
      end
      S_WAIT: begin
        if (row_out.valid) steer16 <= (d == '0) ? '0 : $signed(row_out.z);
        len   <= len_c;
        tprod <= len_c * inverse_speed;
      end
      S_DONE: begin
        if (out_free) begin
          reachable   <= reach_c;
          end_heading <= end13;
          if (flag_unreachable && !reach_c) begin
            path_length <= ars_pkg::NEG_ONE;
            travel_time <= ars_pkg::NEG_ONE;
          end else begin
            path_length <= {1'b0, len};
            travel_time <= {1'b0, tim_c};
          end
        end
      end
      default: ;
    endcase
  end

  assign steering_command = steering_hold;

endmodule

>>> hdl/ars_cordic_cell.sv
// One CORDIC iteration with a fixed shift, registered output.
// Depends on ars_pkg for the data type and arctangent table.
`timescale 1ns / 1ps
module ars_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  ars_pkg::cdc_t din,
  output ars_pkg::cdc_t dout
);

  logic signed [ars_pkg::CW-1:0] xs, ys;
  logic signed [ars_pkg::ZW-1:0] at;
  logic                          pos;

  assign xs  = $signed(din.x) >>> IDX;
  assign ys  = $signed(din.y) >>> IDX;
  assign at  = $signed({{(ars_pkg::ZW-17){1'b0}}, ars_pkg::atan_q16(IDX)});
  // vectoring drives y toward zero, rotation drives z toward zero
  assign pos = din.vec ? din.y[ars_pkg::CW-1] : ~din.z[ars_pkg::ZW-1];

  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else dout.valid <= din.valid;
    dout.vec <= din.vec;
    if (pos) begin
      dout.x <= $signed(din.x) - ys;
      dout.y <= $signed(din.y) + xs;
      dout.z <= $signed(din.z) - at;
    end else begin
      dout.x <= $signed(din.x) + ys;
      dout.y <= $signed(din.y) - xs;
      dout.z <= $signed(din.z) + at;
    end
  end

endmodule

>>> hdl/ars_divider.sv
// Radix-2 restoring divider: floor(num * 2^14 / den), 31 quotient bits.
// Depends on ars_pkg for the status type.
`timescale 1ns / 1ps
module ars_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [53:0]        num,
  input  logic [30:0]        den,
  output ars_pkg::div_stat_t stat,
  output logic [30:0]        quot
);

  logic [30:0] rem;
  logic [30:0] low;
  logic [4:0]  cnt;
  logic        busy;
  logic        ovf_c;
  logic [31:0] trial;

  assign ovf_c = num >= {6'd0, den, 17'd0};
  assign trial = {rem, low[30]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      stat.done <= 1'b0;
    end else if (start) begin
      busy      <= ~ovf_c;
      stat.done <= ovf_c;
    end else if (busy && cnt == 5'd30) begin
      busy      <= 1'b0;
      stat.done <= 1'b1;
    end
    if (start) begin
      stat.ovf <= ovf_c;
      rem      <= num[47:17];
      low      <= {num[16:0], 14'd0};
      cnt      <= 5'd0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem  <= 31'(trial - {1'b0, den});
        quot <= {quot[29:0], 1'b1};
      end else begin
        rem  <= trial[30:0];
        quot <= {quot[29:0], 1'b0};
      end
      low <= {low[29:0], 1'b0};
      cnt <= cnt + 5'd1;
    end
  end

endmodule

>>> test/ars_checker.sv
// Checker for the arc reachability block: tracks APB writes, predicts each
// result from accepted input transactions and compares. Depends on ars_pkg.
`timescale 1ns / 1ps
module ars_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [15:0] origin_heading,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic               update_steering,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] path_length,
  input  logic signed [31:0] travel_time,
  input  logic signed [15:0] end_heading,
  input  logic signed [31:0] steering_command,
  input  logic               reachable,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);

  typedef struct {
    logic [31:0] len;
    logic [31:0] tim;
    logic [15:0] endh;
    logic [31:0] steer;
    logic        reach;
  } arc_result_t;

  localparam longint PI_Q16   = 205887;
  localparam longint HPI_Q16  = 102944;
  localparam longint TPI_Q16  = 411775;
  localparam longint GAIN_Q30 = 652032874;
  localparam longint SAT      = 64'h7FFF_FFFF;

  arc_result_t arc_q[$];
  logic [15:0] wb;
  logic [14:0] steer_lim;
  logic [15:0] ratio;
  logic [31:0] inv_spd;
  logic        flag_unr;
  logic [31:0] hold;

  function automatic longint atan_step(int i);
    longint tbl[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? tbl[i] : 0;
  endfunction

  function automatic longint wrap_q16(longint a);
    for (int k = 0; k < 4; k++) begin
      if (a > PI_Q16) a -= TPI_Q16;
      else if (a <= -PI_Q16) a += TPI_Q16;
    end
    return a;
  endfunction

  // atan2 and gain-corrected magnitude
  function automatic void polar(input longint xi, input longint yi,
                                output longint mag, output longint ang);
    longint x, y, z, t, xs, ys;
    longint unsigned prod;
    x = xi; y = yi; z = 0;
    if (x < 0) begin
      if (y >= 0) begin t = x; x = y; y = -t; z = HPI_Q16; end
      else begin t = x; x = -y; y = t; z = -HPI_Q16; end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y >= 0) begin x += ys; y -= xs; z += atan_step(i); end
      else begin x -= ys; y += xs; z -= atan_step(i); end
    end
    if (x < 0) x = 0;
    prod = longint'(x) * GAIN_Q30 + (64'd1 << 29);
    mag = longint'(prod >> 30);
    ang = z;
  endfunction

  function automatic longint sin_q30(longint b);
    longint x, y, z, xs, ys;
    x = GAIN_Q30; y = 0; z = b;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (z >= 0) begin x -= ys; y += xs; z -= atan_step(i); end
      else begin x += ys; y -= xs; z += atan_step(i); end
    end
    if (y < 0) y = 0;
    if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
    return y;
  endfunction

  function automatic arc_result_t predict_arc(longint ox, longint oy, longint hd,
                                              longint gx, longint gy, logic upd);
    arc_result_t r;
    longint dx, dy, d, theta, alpha, a, b, s, len, tim, end16, end13;
    longint steer16, steer13, mag13, n, dummy;
    longint unsigned num, q, rem, v, t, m;
    logic reach;
    dx = gx - ox; dy = gy - oy;
    d = 0; alpha = 0; steer16 = 0;
    if (dx != 0 || dy != 0) begin
      polar(dx, dy, d, theta);
      alpha = wrap_q16(theta - hd * 8);
    end
    a = alpha < 0 ? -alpha : alpha;
    b = a > HPI_Q16 ? PI_Q16 - a : a;
    s = sin_q30(b);
    if (d == 0) len = 0;
    else if (a == 0) len = d > SAT ? SAT : d;
    else if (s <= 0) len = SAT;
    else begin
      num = longint'(d) * longint'(a);
      q = num / s; rem = num % s;
      if (q >= (64'd1 << 17)) len = SAT;
      else begin
        v = (q << 14) + (rem << 14) / s;
        len = v > SAT ? SAT : longint'(v);
      end
    end
    t = (longint'(len) * longint'({32'd0, inv_spd})) >> 16;
    tim = t > SAT ? SAT : longint'(t);
    end16 = wrap_q16(hd * 8 + 2 * alpha);
    end13 = (end16 + 4) >>> 3;
    if (d != 0) begin
      n = longint'((2 * longint'({48'd0, wb}) * s) >> 22);
      if (alpha < 0) n = -n;
      polar(d, n, dummy, steer16);
    end
    steer13 = (steer16 + 4) >>> 3;
    mag13 = steer13 < 0 ? -steer13 : steer13;
    reach = mag13 < longint'({49'd0, steer_lim});
    if (upd) begin
      m = (longint'(mag13) * longint'({48'd0, ratio})) >> 8;
      if (m > SAT) m = SAT;
      hold = steer13 < 0 ? 32'(-m) : 32'(m);
    end
    if (flag_unr && !reach) begin len = -65536; tim = -65536; end
    r.len = 32'(len); r.tim = 32'(tim); r.endh = 16'(end13);
    r.steer = hold; r.reach = reach;
    return r;
  endfunction

  assign pending = arc_q.size();

  always @(posedge clk) begin
    arc_result_t e;
    if (rst) begin
      wb <= ars_pkg::WHEELBASE_RST; steer_lim <= ars_pkg::MAX_STEER_RST;
      ratio <= ars_pkg::RATIO_RST;
      inv_spd <= ars_pkg::INV_SPEED_RST; flag_unr <= 1'b0; hold = '0;
      arc_q.delete();
      errors <= 0; results_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          ars_pkg::REG_WHEELBASE: wb <= pwdata[15:0];
          ars_pkg::REG_MAX_STEER: steer_lim <= pwdata[14:0];
          ars_pkg::REG_RATIO:     ratio <= pwdata[15:0];
          ars_pkg::REG_INV_SPEED: inv_spd <= pwdata;
          ars_pkg::REG_FLAG:      flag_unr <= pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        arc_q.insert(arc_q.size(), predict_arc(origin_x, origin_y, origin_heading,
                                               goal_x, goal_y, update_steering));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (arc_q.size() == 0) begin
          $display("%0t: result with nothing expected, got len %h", $time, path_length);
          errors <= errors + 1;
        end else begin
          e = arc_q.pop_front();
          if (e.len !== path_length || e.tim !== travel_time || e.endh !== end_heading ||
              e.steer !== steering_command || e.reach !== reachable) begin
            $display("%0t: mismatch exp len %h tim %h end %h steer %h reach %b", $time,
                     e.len, e.tim, e.endh, e.steer, e.reach);
            $display("%0t:          got len %h tim %h end %h steer %h reach %b", $time,
                     path_length, travel_time, end_heading, steering_command, reachable);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> test/arc_reachability_and_steering_tb.sv
// Top of the arc reachability testbench: clock, reset, APB setup, stimulus
// and verdict. Depends on ars_pkg, ars_checker and the block itself.
`timescale 1ns / 1ps
module arc_reachability_and_steering_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] origin_x = '0, origin_y = '0, goal_x = '0, goal_y = '0;
  logic signed [15:0] origin_heading = '0;
  logic update_steering = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] path_length, travel_time, steering_command;
  logic signed [15:0] end_heading;
  logic reachable;
  int errors, pending, results_seen;
  bit calm = 1'b0;    // no idling on either side while set
  int items_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  arc_reachability_and_steering dut (.*);

  ars_checker chk (.*);

  // Receiver stalls about a quarter of the cycles unless in a calm stretch.
  always @(posedge clk)
    out_ready <= calm || ($urandom_range(99) >= 24);

  // APB write with setup and access phases; register takes it at the access-phase edge.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] wb, input logic [14:0] lim,
                          input logic [15:0] ratio, input logic [31:0] inv,
                          input logic flag);
    apb_write(ars_pkg::REG_WHEELBASE, {16'd0, wb});
    apb_write(ars_pkg::REG_MAX_STEER, {17'd0, lim});
    apb_write(ars_pkg::REG_RATIO, {16'd0, ratio});
    apb_write(ars_pkg::REG_INV_SPEED, inv);
    apb_write(ars_pkg::REG_FLAG, {31'd0, flag});
  endtask

  // Block is idle once every transaction has come back.
  task automatic drain();
    if (in_valid) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // One input transaction; valid held until accepted.
  task automatic send_goal(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [15:0] hd, input logic [31:0] gx,
                           input logic [31:0] gy, input logic upd);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    origin_x <= ox; origin_y <= oy; origin_heading <= hd;
    goal_x <= gx; goal_y <= gy; update_steering <= upd;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_random();
    logic [31:0] ox, oy, gx, gy;
    logic [15:0] hd;
    int kind;
    kind = $urandom_range(99);
    ox = $urandom; oy = $urandom;
    hd = 16'($signed($urandom_range(51472)) - 25736);
    if (kind < 60) begin
      // nearby goal, the usual planning case
      ox = $signed(ox) >>> $urandom_range(0, 10);
      oy = $signed(oy) >>> $urandom_range(0, 10);
      gx = ox + ($signed($urandom) >>> $urandom_range(4, 20));
      gy = oy + ($signed($urandom) >>> $urandom_range(4, 20));
    end else if (kind < 85) begin
      gx = $urandom; gy = $urandom;
      if ($urandom_range(3) == 0) hd = 16'($urandom);
    end else if (kind < 90) begin
      gx = ox; gy = oy;                       // goal on the origin
    end else if (kind < 95) begin
      hd = 16'd0; gx = ox + $urandom_range(1, 1 << 24); gy = oy;   // dead ahead
    end else begin
      hd = 16'd0; gx = ox - $urandom_range(1, 1 << 24); gy = oy;   // directly behind
    end
    send_goal(ox, oy, hd, gx, gy, 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: reset register values
    send_goal(32'd0, 32'd0, 16'd0, 32'd0, 32'd0, 1'b1);                   // goal at origin
    send_goal(32'd0, 32'd0, 16'd0, 32'h0005_0000, 32'd0, 1'b1);           // zero bearing
    send_goal(32'd0, 32'd0, 16'd0, 32'hFFFB_0000, 32'd0, 1'b1);           // behind
    send_goal(32'h8000_0000, 32'h8000_0000, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_goal(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_goal(32'h7FFF_FFFF, 32'h8000_0000, 16'd25736, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_goal(32'd0, 32'd0, -16'sd25736, 32'h0001_0000, 32'h0001_0000, 1'b1);
    send_goal(32'd0, 32'd0, 16'h7FFF, 32'h0003_0000, 32'hFFFF_0000, 1'b1);  // heading past pi
    send_goal(32'd0, 32'd0, 16'h8000, 32'h0000_0001, 32'h0000_0001, 1'b1);
    send_goal(32'd0, 32'd0, 16'd0, 32'h0001_0000, 32'h0000_0100, 1'b1);     // near-straight
    send_goal(32'd0, 32'd0, 16'd12868, 32'd0, 32'h0010_0000, 1'b0);
    send_goal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'd0, 1'b1);
    drain();

    // unknown register index is ignored
    apb_write(3'd7, 32'hFFFF_FFFF);
    // extremes, flag set
    set_regs(16'hFFFF, 15'd25736, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_goal(32'd0, 32'd0, 16'd0, 32'h0000_1000, 32'h0010_0000, 1'b1);
    send_goal(32'd0, 32'd0, 16'd0, 32'h7FFF_FFFF, 32'h0000_0010, 1'b1);
    send_goal(32'd0, 32'd0, 16'd0, 32'hFFFB_0000, 32'd0, 1'b1);
    send_goal(32'd0, 32'd0, 16'd0, 32'h0002_0000, 32'h0002_0000, 1'b1);
    drain();
    set_regs(16'd0, 15'd0, 16'd0, 32'd0, 1'b1);
    send_goal(32'd0, 32'd0, 16'd0, 32'h0002_0000, 32'h0002_0000, 1'b1);
    send_goal(32'd0, 32'd0, 16'd0, 32'h0002_0000, 32'd0, 1'b1);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;  // keep the zero setting
        1: set_regs(16'hFFFF, 15'd25736, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        2: set_regs(ars_pkg::WHEELBASE_RST, ars_pkg::MAX_STEER_RST, ars_pkg::RATIO_RST,
                    ars_pkg::INV_SPEED_RST, 1'b1);
        3: set_regs(16'hFFFF, 15'd1, 16'd256, 32'h0001_0000, 1'b1);
        default: set_regs(16'($urandom), 15'($urandom_range(25736)), 16'($urandom),
                          $urandom, 1'($urandom_range(1)));
      endcase
      calm = (ph == 5);
      for (int k = 0; k < 125; k++) begin
        send_random();
        // let the sender wait for every result once
        if (ph == 4 && k == 60) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      calm = 1'b0;
      drain();
    end

    $display("Covered %0d goal checks and %0d results over ten register settings,",
             items_sent, results_seen);
    $display("with origin goals, straight and reversed bearings and saturating cases.");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
